// File: src/epst_pkg.sv
// Shared types, constants and command codes of the encoder position and speed tracker.
// No dependencies; used by every module under src.
package epst_pkg;

  localparam int ANGLE_TABLE_SIZE = 1024;
  localparam int ANGLE_BITS       = $clog2(ANGLE_TABLE_SIZE);
  localparam int ELEC_IDX_W       = 10;

  // divider geometry: numerator left-aligned in DIV_W bits
  localparam int DIV_W  = 33;
  localparam int NB_W   = 6;
  localparam int IDX_NB = 15 + ANGLE_BITS;

  // configuration register indexes
  localparam logic [1:0] REG_CPR    = 2'd0;
  localparam logic [1:0] REG_CPE    = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [15:0] CPR_RESET    = 16'd4096;
  localparam logic [15:0] CPE_RESET    = 16'd1024;
  localparam logic [15:0] OFFSET_RESET = 16'd0;
  localparam logic [14:0] THRESH_RESET = 15'd1000;

  // input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_INDEX  = 1'b1;

  // divider operations
  localparam logic [2:0] OP_DDHI = 3'd0;
  localparam logic [2:0] OP_DDLO = 3'd1;
  localparam logic [2:0] OP_PDHI = 3'd2;
  localparam logic [2:0] OP_PDLO = 3'd3;
  localparam logic [2:0] OP_MRAW = 3'd4;
  localparam logic [2:0] OP_MORG = 3'd5;
  localparam logic [2:0] OP_MOFF = 3'd6;
  localparam logic [2:0] OP_IDX  = 3'd7;

  typedef struct packed {
    logic        command;
    logic [15:0] raw_count;
    logic        overflow_flag;
    logic        underflow_flag;
    logic        counting_up;
  } in_t;

  typedef struct packed {
    logic signed [31:0]           position;
    logic signed [15:0]           count_diff;
    logic        [ELEC_IDX_W-1:0] elec_angle_index;
  } out_t;

  typedef struct packed {
    logic [15:0] counts_per_rev;
    logic [15:0] counts_per_elec_cycle;
    logic [15:0] index_offset;
    logic [14:0] glitch_threshold;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [2:0] op;
    logic       wb;
    logic       mul;
    logic       pos;
    logic       commit;
    logic       fold;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_index;
    logic dd_hi;
    logic dd_lo;
    logic pd_hi;
    logic pd_lo;
    logic div_busy;
    logic div_done;
  } sts_t;

endpackage

// File: src/epst_div.sv
// Restoring divider, one quotient bit per cycle, numerator left-aligned.
// Depends on epst_pkg.
module epst_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [epst_pkg::DIV_W-1:0]  num,
  input  logic [epst_pkg::NB_W-1:0]   nbits,
  input  logic [15:0]                 den,
  output logic [epst_pkg::DIV_W-1:0]  quo,
  output logic [15:0]                 rem,
  output logic                        busy,
  output logic                        done
);
  import epst_pkg::*;

  logic [DIV_W-1:0] sh_r, sh_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [NB_W-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [16:0]      rem_sh;
  logic [16:0]      rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, sh_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = (rem_sh >= {1'b0, den});

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = num;
      rem_nxt  = '0;
      cnt_nxt  = nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[DIV_W-2:0], ge};
      rem_nxt = ge ? rem_sub[15:0] : rem_sh[15:0];
      cnt_nxt = cnt_r - NB_W'(1);
      if (cnt_r == NB_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign quo  = sh_r;
  assign rem  = rem_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

// File: src/epst_dp.sv
// Datapath: tracker state, glitch correction arithmetic, angle folding, result register.
// Depends on epst_pkg and epst_div.
module epst_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  epst_pkg::cfg_t cfg,
  input  epst_pkg::in_t  in_data,
  input  epst_pkg::cmd_t cmd,
  output epst_pkg::sts_t sts,
  output epst_pkg::out_t out_data
);
  import epst_pkg::*;

  in_t          in_r;
  logic [15:0]  cpr_r, e_r;
  logic         first_r;
  logic [14:0]  eo_r;
  logic [16:0]  mech_r;
  logic [15:0]  praw_r, pcd_r;
  logic [31:0]  turn_r, ppos_r;
  logic [17:0]  dd_r;
  logic [31:0]  mul_r, pos_r;
  logic [33:0]  pd_r;
  logic [15:0]  t_r, o_r, f_r;
  logic [14:0]  a_r;
  logic [ELEC_IDX_W-1:0] idx_r;
  out_t         out_r;

  logic [15:0]  cpr_c, e_c;
  logic [15:0]  diff;
  logic [15:0]  dd16;
  logic [17:0]  thr18, cpr18, rem18;
  logic [33:0]  thr34, cpr34, rem34;
  logic [17:0]  n_ddhi, n_ddlo, dd_hi_v, dd_lo_v;
  logic [33:0]  n_pdhi, n_pdlo, pd_hi_v, pd_lo_v;
  logic [47:0]  prod;
  logic [31:0]  pos_c, pdiff;
  logic [15:0]  c_fold, a_fold;
  logic [DIV_W-1:0] num;
  logic [NB_W-1:0]  nbits;
  logic [15:0]  den;
  logic [DIV_W-1:0] quo;
  logic [15:0]  rem;
  logic         busy, done;

  always_comb begin
    priority if (cfg.counts_per_rev < 16'd2)       cpr_c = 16'd2;
    else if (cfg.counts_per_rev > 16'd32768)        cpr_c = 16'd32768;
    else                                             cpr_c = cfg.counts_per_rev;
    priority if (cfg.counts_per_elec_cycle < 16'd1) e_c = 16'd1;
    else if (cfg.counts_per_elec_cycle > 16'd32768) e_c = 16'd32768;
    else                                             e_c = cfg.counts_per_elec_cycle;
  end

  // overflow wins over underflow
  always_comb begin
    priority if (in_data.overflow_flag) diff = in_data.raw_count + cpr_c - praw_r;
    else if (in_data.underflow_flag)    diff = in_data.raw_count - praw_r - cpr_c;
    else                                diff = in_data.raw_count - praw_r;
  end
  assign dd16 = diff - pcd_r;

  assign thr18 = {3'b0, cfg.glitch_threshold};
  assign cpr18 = {2'b0, cpr_r};
  assign rem18 = {2'b0, rem};
  assign thr34 = {19'b0, cfg.glitch_threshold};
  assign cpr34 = {18'b0, cpr_r};
  assign rem34 = {18'b0, rem};

  // ceil-division numerators and the corrected jump from the remainder
  assign n_ddhi  = dd_r + cpr18 - thr18 - 18'd1;
  assign n_ddlo  = cpr18 - thr18 - dd_r - 18'd1;
  assign dd_hi_v = thr18 + rem18 - cpr18 + 18'd1;
  assign dd_lo_v = cpr18 - thr18 - rem18 - 18'd1;
  assign n_pdhi  = pd_r + cpr34 - thr34 - 34'd1;
  assign n_pdlo  = cpr34 - thr34 - pd_r - 34'd1;
  assign pd_hi_v = thr34 + rem34 - cpr34 + 34'd1;
  assign pd_lo_v = cpr34 - thr34 - rem34 - 34'd1;

  assign prod  = turn_r * cpr_r;
  assign pos_c = mul_r + {16'b0, in_r.raw_count} - {{15{mech_r[16]}}, mech_r};
  assign pdiff = pos_c - ppos_r;

  assign c_fold = (t_r >= o_r) ? (t_r - o_r) : (t_r + e_r - o_r);
  assign a_fold = (c_fold >= f_r) ? (c_fold - f_r) : (c_fold + e_r - f_r);

  always_comb begin
    num   = '0;
    nbits = NB_W'(16);
    den   = e_r;
    unique case (cmd.op)
      OP_DDHI: begin num = {n_ddhi[16:0], 16'b0};   nbits = NB_W'(17); den = cpr_r; end
      OP_DDLO: begin num = {n_ddlo[16:0], 16'b0};   nbits = NB_W'(17); den = cpr_r; end
      OP_PDHI: begin num = n_pdhi[DIV_W-1:0];       nbits = NB_W'(DIV_W); den = cpr_r; end
      OP_PDLO: begin num = n_pdlo[DIV_W-1:0];       nbits = NB_W'(DIV_W); den = cpr_r; end
      OP_MRAW: begin num = {in_r.raw_count, 17'b0}; nbits = NB_W'(16); end
      OP_MORG: begin num = {eo_r, 18'b0};           nbits = NB_W'(15); end
      OP_MOFF: begin num = {cfg.index_offset, 17'b0}; nbits = NB_W'(16); end
      OP_IDX:  begin num = {a_r, 18'b0};            nbits = NB_W'(IDX_NB); end
      default: begin num = '0; end
    endcase
  end

  epst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .nbits (nbits),
    .den   (den),
    .quo   (quo),
    .rem   (rem),
    .busy  (busy),
    .done  (done)
  );

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      eo_r    <= '0;
      mech_r  <= '0;
      praw_r  <= '0;
      pcd_r   <= '0;
      turn_r  <= '0;
      ppos_r  <= '0;
    end else begin
      if (cmd.load) begin
        if (in_data.command == CMD_SAMPLE) begin
          priority if (in_data.overflow_flag) turn_r <= turn_r + 32'd1;
          else if (in_data.underflow_flag)    turn_r <= turn_r - 32'd1;
          else                                turn_r <= turn_r;
        end else if (first_r) begin
          mech_r  <= in_data.counting_up ? {1'b0, in_data.raw_count}
                                         : {1'b0, in_data.raw_count} - {1'b0, cpr_c};
          first_r <= 1'b0;
        end
      end
      if (cmd.mul) pcd_r <= pcd_r + dd_r[15:0];
      if (cmd.wb && cmd.op == OP_PDHI) turn_r <= turn_r - quo[31:0];
      if (cmd.wb && cmd.op == OP_PDLO) turn_r <= turn_r + quo[31:0];
      if (cmd.wb && cmd.op == OP_MRAW && in_r.command == CMD_INDEX) eo_r <= rem[14:0];
      if (cmd.commit) begin
        ppos_r <= pos_r;
        praw_r <= in_r.raw_count;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r  <= in_data;
      cpr_r <= cpr_c;
      e_r   <= e_c;
      dd_r  <= {{2{dd16[15]}}, dd16};
    end
    if (cmd.mul) mul_r <= prod[31:0];
    if (cmd.pos) begin
      pos_r <= pos_c;
      pd_r  <= {{2{pdiff[31]}}, pdiff};
    end
    if (cmd.fold) a_r <= a_fold[14:0];
    if (cmd.out_load) begin
      out_r.position         <= ppos_r;
      out_r.count_diff       <= pcd_r;
      out_r.elec_angle_index <= idx_r;
    end
    if (cmd.wb) begin
      unique case (cmd.op)
        OP_DDHI: dd_r <= dd_hi_v;
        OP_DDLO: dd_r <= dd_lo_v;
        OP_PDHI: begin pd_r <= pd_hi_v; pos_r <= ppos_r + pd_hi_v[31:0]; end
        OP_PDLO: begin pd_r <= pd_lo_v; pos_r <= ppos_r + pd_lo_v[31:0]; end
        OP_MRAW: t_r <= rem;
        OP_MORG: o_r <= rem;
        OP_MOFF: f_r <= rem;
        OP_IDX:  idx_r <= quo[ELEC_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign sts.is_index = (in_r.command == CMD_INDEX);
  assign sts.dd_hi    = ($signed(dd_r) > $signed(thr18));
  assign sts.dd_lo    = ($signed(dd_r + thr18) < 0);
  assign sts.pd_hi    = ($signed(pd_r) > $signed(thr34));
  assign sts.pd_lo    = ($signed(pd_r + thr34) < 0);
  assign sts.div_busy = busy;
  assign sts.div_done = done;

  assign out_data = out_r;

endmodule

// File: src/epst_ctrl.sv
// Controller: sequences one transaction through the datapath and owns both handshakes.
// Depends on epst_pkg.
module epst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  epst_pkg::sts_t sts,
  output epst_pkg::cmd_t cmd
);
  import epst_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DDHI = 4'd1;
  localparam logic [3:0] S_DDLO = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_POS  = 4'd4;
  localparam logic [3:0] S_PDHI = 4'd5;
  localparam logic [3:0] S_PDLO = 4'd6;
  localparam logic [3:0] S_MRAW = 4'd7;
  localparam logic [3:0] S_MORG = 4'd8;
  localparam logic [3:0] S_MOFF = 4'd9;
  localparam logic [3:0] S_FOLD = 4'd10;
  localparam logic [3:0] S_IDX  = 4'd11;
  localparam logic [3:0] S_WAIT = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load  = 1'b1;
          state_nxt = S_DDHI;
        end
      end
      S_DDHI: begin
        // index items skip the whole tracking part
        if (sts.is_index) state_nxt = S_MRAW;
        else if (sts.dd_hi) begin
          cmd.op = OP_DDHI; cmd.div_start = 1'b1; op_nxt = OP_DDHI; state_nxt = S_WAIT;
        end else state_nxt = S_DDLO;
      end
      S_DDLO: begin
        if (sts.dd_lo) begin
          cmd.op = OP_DDLO; cmd.div_start = 1'b1; op_nxt = OP_DDLO; state_nxt = S_WAIT;
        end else state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = S_PDHI;
      end
      S_PDHI: begin
        if (sts.pd_hi) begin
          cmd.op = OP_PDHI; cmd.div_start = 1'b1; op_nxt = OP_PDHI; state_nxt = S_WAIT;
        end else state_nxt = S_PDLO;
      end
      S_PDLO: begin
        if (sts.pd_lo) begin
          cmd.op = OP_PDLO; cmd.div_start = 1'b1; op_nxt = OP_PDLO; state_nxt = S_WAIT;
        end else state_nxt = S_MRAW;
      end
      S_MRAW: begin
        cmd.commit    = !sts.is_index;
        cmd.op        = OP_MRAW;
        cmd.div_start = 1'b1;
        op_nxt        = OP_MRAW;
        state_nxt     = S_WAIT;
      end
      S_MORG: begin
        cmd.op = OP_MORG; cmd.div_start = 1'b1; op_nxt = OP_MORG; state_nxt = S_WAIT;
      end
      S_MOFF: begin
        cmd.op = OP_MOFF; cmd.div_start = 1'b1; op_nxt = OP_MOFF; state_nxt = S_WAIT;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.op = OP_IDX; cmd.div_start = 1'b1; op_nxt = OP_IDX; state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.wb = 1'b1;
          unique case (op_r)
            OP_DDHI: state_nxt = S_DDLO;
            OP_DDLO: state_nxt = S_MUL;
            OP_PDHI: state_nxt = S_PDLO;
            OP_PDLO: state_nxt = S_MRAW;
            OP_MRAW: state_nxt = S_MORG;
            OP_MORG: state_nxt = S_MOFF;
            OP_MOFF: state_nxt = S_FOLD;
            OP_IDX:  state_nxt = S_OUT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)            out_valid_nxt = 1'b1;
    else if (out_valid_r && out_stall) out_valid_nxt = 1'b1;
    else                         out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_DDHI;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_accept_locks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after accept");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result overwritten before it was taken");

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (sts.div_busy || sts.div_done))
    else $error("waiting on an idle divider");
`endif

endmodule

// File: src/encoder_position_speed_tracker.sv
// Encoder position and speed tracker: APB-style register block, controller and datapath.
// Depends on epst_pkg, epst_ctrl and epst_dp.
//
// Input channel in_valid/in_stall/in_data carries a quadrature count sample
// (command sample) or an index pulse event (command index). Each transaction
// yields exactly one result on out_valid/out_stall/out_data: the multi-turn
// position, the corrected count difference and the electrical angle index.
// One item is processed at a time; in_stall is high from accept until the
// result is written into the output register. All modulo, ceil-division and
// angle scaling go through one shared restoring divider, one bit per cycle.
// A finished result waits in the output register while the next item is
// accepted; if out_stall is still high when the next result is ready, the
// controller holds it until the register is taken.
// rst_n (synchronous) restores register defaults, clears the tracking state
// and marks the first index as pending; no result is valid after reset.
// Configuration must be written only while the block is idle; it is not enforced.
module encoder_position_speed_tracker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  epst_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output epst_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import epst_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counts_per_rev        <= CPR_RESET;
      cfg_r.counts_per_elec_cycle <= CPE_RESET;
      cfg_r.index_offset          <= OFFSET_RESET;
      cfg_r.glitch_threshold      <= THRESH_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CPR:    cfg_r.counts_per_rev        <= pwdata[15:0];
        REG_CPE:    cfg_r.counts_per_elec_cycle <= pwdata[15:0];
        REG_OFFSET: cfg_r.index_offset          <= pwdata[15:0];
        REG_THRESH: cfg_r.glitch_threshold      <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CPR:    prdata = {16'b0, cfg_r.counts_per_rev};
      REG_CPE:    prdata = {16'b0, cfg_r.counts_per_elec_cycle};
      REG_OFFSET: prdata = {16'b0, cfg_r.index_offset};
      REG_THRESH: prdata = {17'b0, cfg_r.glitch_threshold};
      default:    prdata = '0;
    endcase
  end

  epst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  epst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the encoder position and speed tracker.
// Depends on epst_pkg and encoder_position_speed_tracker; drives APB writes,
// bursty encoder transactions and a stalling receiver, and checks every result.
`timescale 1ns / 1ps

module tb;
  import epst_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  encoder_position_speed_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // tracker shadow: registers and state
  bit [15:0] sh_cpr, sh_cpe, sh_off;
  bit [14:0] sh_thr;
  bit        trk_first;
  bit [31:0] trk_eorg;
  int        trk_morg;
  bit [31:0] trk_raw, trk_diff, trk_turns, trk_pos;

  in_t  pending_q[$];
  out_t tracker_q[$];
  int   n_queued = 0;
  int   n_checked = 0;
  int   errors = 0;

  // encoder motion generator state
  int enc_raw = 0;
  int enc_vel = 0;

  function automatic longint rev_len();
    if (sh_cpr < 2) return 2;
    if (sh_cpr > 32768) return 32768;
    return sh_cpr;
  endfunction

  function automatic longint cyc_len();
    if (sh_cpe < 1) return 1;
    if (sh_cpe > 32768) return 32768;
    return sh_cpe;
  endfunction

  function automatic out_t track(in_t x);
    longint cpr, e, thr, dd, pd, k, t, c, a;
    bit [31:0] raw, diff, pos, cpr32;
    bit [15:0] d16;
    out_t r;
    cpr = rev_len();
    cpr32 = cpr[31:0];
    raw = {16'd0, x.raw_count};
    e = cyc_len();
    if (x.command == CMD_INDEX) begin
      trk_eorg = raw % e[31:0];
      if (trk_first) begin
        trk_morg = x.counting_up ? int'(raw) : int'(raw) - int'(cpr);
        trk_first = 1'b0;
      end
    end else begin
      thr = sh_thr;
      if (x.overflow_flag) begin
        diff = raw + cpr32 - trk_raw;
        trk_turns = trk_turns + 1;
      end else if (x.underflow_flag) begin
        diff = raw - (trk_raw + cpr32);
        trk_turns = trk_turns - 1;
      end else begin
        diff = raw - trk_raw;
      end
      d16 = diff[15:0] - trk_diff[15:0];
      dd = longint'($signed(d16));
      if (dd > thr) begin
        k = (dd - thr + cpr - 1) / cpr;
        dd = dd - k * cpr;
      end
      if (dd < -thr) begin
        k = (-thr - dd + cpr - 1) / cpr;
        dd = dd + k * cpr;
      end
      trk_diff = {16'd0, trk_diff[15:0] + dd[15:0]};
      pos = trk_turns * cpr32 + raw - 32'(trk_morg);
      pd = longint'($signed(pos - trk_pos));
      if (pd > thr) begin
        k = (pd - thr + cpr - 1) / cpr;
        trk_turns = trk_turns - k[31:0];
        pos = pos - k[31:0] * cpr32;
      end
      pd = longint'($signed(pos - trk_pos));
      if (pd < -thr) begin
        k = (-thr - pd + cpr - 1) / cpr;
        trk_turns = trk_turns + k[31:0];
        pos = pos + k[31:0] * cpr32;
      end
      trk_raw = raw;
      trk_pos = pos;
    end
    t = raw % e;
    c = (t + e - (trk_eorg % e)) % e;
    a = (c + e - (sh_off % e)) % e;
    r.position = trk_pos;
    r.count_diff = trk_diff[15:0];
    r.elec_angle_index = 10'((a * ANGLE_TABLE_SIZE) / e);
    return r;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tracker_q.push_back(track(in_data));
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between random modes
  int stall_mode = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (tracker_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = tracker_q.pop_front();
        if (out_data.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time,
                   want.position, out_data.position);
          errors++;
        end
        if (out_data.count_diff !== want.count_diff) begin
          $display("%0t: count_diff expected %0d actual %0d", $time,
                   want.count_diff, out_data.count_diff);
          errors++;
        end
        if (out_data.elec_angle_index !== want.elec_angle_index) begin
          $display("%0t: elec_angle_index expected %0d actual %0d", $time,
                   want.elec_angle_index, out_data.elec_angle_index);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CPR: sh_cpr = val[15:0];
      REG_CPE: sh_cpe = val[15:0];
      REG_OFFSET: sh_off = val[15:0];
      default: sh_thr = val[14:0];
    endcase
  endtask

  task automatic queue_item(in_t x);
    pending_q.push_back(x);
    n_queued++;
  endtask

  task automatic mk_item();
    in_t x;
    int cpr, nxt, sel;
    cpr = int'(rev_len());
    sel = $urandom_range(0, 99);
    x = '0;
    if (sel < 10) begin
      x = in_t'($urandom);
    end else if (sel < 16) begin
      x.command = CMD_INDEX;
      x.raw_count = 16'(enc_raw);
      x.counting_up = (enc_vel >= 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end else begin
      if ($urandom_range(0, 9) == 0) enc_vel = $urandom_range(0, 2 * cpr) - cpr;
      else enc_vel = enc_vel + $urandom_range(0, 20) - 10;
      nxt = enc_raw + enc_vel;
      x.command = CMD_SAMPLE;
      while (nxt >= cpr) begin
        nxt -= cpr;
        x.overflow_flag = 1'b1;
      end
      while (nxt < 0) begin
        nxt += cpr;
        x.underflow_flag = 1'b1;
      end
      if (sel < 20) nxt = $urandom_range(0, cpr - 1);  // glitch
      enc_raw = nxt;
      x.raw_count = 16'(nxt);
      x.counting_up = 1'($urandom_range(0, 1));
    end
    queue_item(x);
  endtask

  task automatic wait_idle();
    while (n_checked != n_queued) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  initial begin
    logic [15:0] cfgs[8][3];
    logic [14:0] thrs[8];
    sh_cpr = CPR_RESET;
    sh_cpe = CPE_RESET;
    sh_off = OFFSET_RESET;
    sh_thr = THRESH_RESET;
    trk_first = 1'b1;
    trk_eorg = 0;
    trk_morg = 0;
    trk_raw = 0;
    trk_diff = 0;
    trk_turns = 0;
    trk_pos = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both commands, flag combinations
    queue_item('{CMD_SAMPLE, 16'd0, 1'b0, 1'b0, 1'b0});
    queue_item('{CMD_SAMPLE, 16'd4095, 1'b0, 1'b0, 1'b1});
    queue_item('{CMD_SAMPLE, 16'd10, 1'b1, 1'b0, 1'b0});
    queue_item('{CMD_SAMPLE, 16'd4000, 1'b0, 1'b1, 1'b0});
    queue_item('{CMD_SAMPLE, 16'd20, 1'b1, 1'b1, 1'b0});
    queue_item('{CMD_INDEX, 16'd100, 1'b0, 1'b0, 1'b0});
    queue_item('{CMD_INDEX, 16'd3000, 1'b1, 1'b1, 1'b1});
    queue_item('{CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 1'b0});
    queue_item('{CMD_SAMPLE, 16'd2000, 1'b0, 1'b0, 1'b0});
    queue_item('{CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 1'b1});
    queue_item('{CMD_INDEX, 16'hFFFF, 1'b0, 1'b0, 1'b1});
    queue_item('{CMD_SAMPLE, 16'h8000, 1'b0, 1'b1, 1'b1});
    wait_idle();

    cfgs = '{'{16'd2, 16'd1, 16'd0}, '{16'd32768, 16'd32768, 16'd32768},
             '{16'd0, 16'd0, 16'd65535}, '{16'd65535, 16'd65535, 16'd7},
             '{16'd1, 16'd3, 16'd5}, '{16'd1000, 16'd77, 16'd200},
             '{16'd4096, 16'd1024, 16'd300}, '{16'd513, 16'd2048, 16'd40000}};
    thrs = '{15'd1, 15'd32767, 15'd1000, 15'd5, 15'd1, 15'd50, 15'd200, 15'd32767};
    for (int p = 0; p < 8; p++) begin
      reg_write(REG_CPR, {16'd0, cfgs[p][0]});
      reg_write(REG_CPE, {16'd0, cfgs[p][1]});
      reg_write(REG_OFFSET, {16'd0, cfgs[p][2]});
      reg_write(REG_THRESH, {17'd0, thrs[p]});
      enc_raw = 0;
      enc_vel = 0;
      for (int i = 0; i < 75; i++) mk_item();
      wait_idle();
    end

    if (errors == 0 && tracker_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/epst_pkg.sv
src/epst_div.sv
src/epst_dp.sv
src/epst_ctrl.sv
src/encoder_position_speed_tracker.sv
tb/sv/tb.sv
